>>> rtl/core/next_fit_handle_table_unit_macros.svh
// Assertion macros for the next-fit handle table checker.
// Included by the checker file only; depends on nothing else.
`ifndef NEXT_FIT_HANDLE_TABLE_UNIT_MACROS_SVH
`define NEXT_FIT_HANDLE_TABLE_UNIT_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define NFHT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("%m: assertion failed");

// Concurrent assertion that also holds through reset.
`define NFHT_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

>>> rtl/core/nfht_pkg.sv
// Shared types, widths and codes of the next-fit handle table.
// No dependencies; all files of the block but the RAM and the macros header use it.
package nfht_pkg;

    // Default parameter values.
    localparam int unsigned DEPTH_DEF        = 64;
    localparam int unsigned HANDLE_WIDTH_DEF = 32;

    // Fixed widths of the channel fields and the register.
    localparam int unsigned IN_HANDLE_W = 32;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned SLOT_W      = 6;
    localparam int unsigned COUNT_W     = 7;
    localparam int unsigned ASIZE_W     = 7;

    localparam logic [ASIZE_W-1:0] ASIZE_RESET = 7'd64;

    // Operation codes.
    typedef enum logic {
        OP_ADD    = 1'b0,
        OP_REMOVE = 1'b1
    } t_op;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_ZERO      = 2'd3
    } t_status;

    // One result as handed from the sequencer to the output register.
    typedef struct packed {
        t_status              status;
        logic [SLOT_W-1:0]    slot;
        logic [COUNT_W-1:0]   used_count;
    } t_result;

endpackage

>>> rtl/core/nfht_if.sv
// Valid/ready channel interfaces for the request and result streams.
// Depends on nfht_pkg for the field widths.
interface nfht_req_if;
    import nfht_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   op;
    logic [IN_HANDLE_W-1:0] handle;

    modport source (output valid, output op, output handle, input ready);
    modport sink   (input valid, input op, input handle, output ready);
endinterface

interface nfht_res_if;
    import nfht_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  used_count;

    modport source (output valid, output status, output slot, output used_count,
                    input ready);
    modport sink   (input valid, input status, input slot, input used_count,
                    output ready);
endinterface

>>> rtl/core/next_fit_handle_table_unit.sv
// Next-fit handle table. After reset a clearing pass zeroes the slot memory;
// no transaction is accepted until it ends. An add or remove scans k slots
// (1 to the active size), reading one slot per cycle, before its result goes
// to the output register; a zero handle skips the scan. The next transaction
// is taken once the result has moved to the output register, so a transaction
// is not accepted before the one ahead of it has left the sequencer.
module next_fit_handle_table_unit #(
    parameter int unsigned DEPTH        = nfht_pkg::DEPTH_DEF,
    parameter int unsigned HANDLE_WIDTH = nfht_pkg::HANDLE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    nfht_req_if.sink                      i_in,
    nfht_res_if.source                    o_out,
    input  logic                          i_cfg_we,
    input  logic [nfht_pkg::ASIZE_W-1:0]  i_cfg_wdata
);
    import nfht_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);

    logic [ASIZE_W-1:0]      r_active_size;
    logic                    r_out_valid;
    t_result                 r_out;

    logic                    seq_ready;
    logic                    res_valid;
    logic                    res_ready;
    t_result                 res;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [HANDLE_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]           mem_raddr;
    logic [HANDLE_WIDTH-1:0] mem_rdata;

    // Active size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_size <= ASIZE_RESET;
        end else if (i_cfg_we) begin
            r_active_size <= i_cfg_wdata;
        end
    end

    // Slot memory.
    nfht_ram #(
        .WIDTH (HANDLE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Scan sequencer.
    nfht_seq #(
        .DEPTH        (DEPTH),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_in.valid && seq_ready),
        .i_op          (i_in.op),
        .i_handle      (i_in.handle),
        .i_active_size (r_active_size),
        .o_ready       (seq_ready),
        .o_res_valid   (res_valid),
        .o_res         (res),
        .i_res_ready   (res_ready),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_mem_raddr   (mem_raddr),
        .i_mem_rdata   (mem_rdata)
    );

    assign i_in.ready = seq_ready;

    // Output register: takes a result when empty or when the held one is taken.
    assign res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out.status;
    assign o_out.slot       = r_out.slot;
    assign o_out.used_count = r_out.used_count;

endmodule

>>> rtl/core/nfht_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module nfht_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/nfht_seq.sv
// Scan sequencer: clears the slot memory after reset, then runs next-fit add
// and first-match remove scans one slot per cycle. Depends on nfht_pkg.
module nfht_seq #(
    parameter int unsigned DEPTH        = 64,
    parameter int unsigned HANDLE_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_op,
    input  logic [nfht_pkg::IN_HANDLE_W-1:0]  i_handle,
    input  logic [nfht_pkg::ASIZE_W-1:0]      i_active_size,
    output logic                              o_ready,
    output logic                              o_res_valid,
    output nfht_pkg::t_result                 o_res,
    input  logic                              i_res_ready,
    output logic                              o_mem_we,
    output logic [$clog2(DEPTH)-1:0]          o_mem_waddr,
    output logic [HANDLE_WIDTH-1:0]           o_mem_wdata,
    output logic [$clog2(DEPTH)-1:0]          o_mem_raddr,
    input  logic [HANDLE_WIDTH-1:0]           i_mem_rdata
);
    import nfht_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state                  r_state, n_state;
    logic [AW-1:0]           r_clr, n_clr;
    logic [AW-1:0]           r_ptr, n_ptr;
    logic [CW-1:0]           r_count, n_count;
    logic                    r_op, n_op;
    logic [HANDLE_WIDTH-1:0] r_h, n_h;
    logic [AW-1:0]           r_addr, n_addr;
    logic [CW-1:0]           r_iter, n_iter;
    t_result                 r_res, n_res;

    logic [HANDLE_WIDTH-1:0] h_in;
    logic [CW-1:0]           eff_n;
    logic [AW-1:0]           start_addr;
    logic [CW-1:0]           addr_inc;
    logic [AW-1:0]           next_addr;
    logic                    hit;
    logic                    last;

    // Incoming handle at the stored width.
    assign h_in = HANDLE_WIDTH'(i_handle);

    // Effective active size: zero counts as one, anything above the depth as the depth.
    always_comb begin
        priority if (i_active_size == '0) begin
            eff_n = CW'(1);
        end else if (int'(i_active_size) > int'(DEPTH)) begin
            eff_n = CW'(DEPTH);
        end else begin
            eff_n = CW'(i_active_size);
        end
    end

    // First slot of a scan: the next pointer for an add while it lies inside
    // the active part, otherwise slot zero.
    assign start_addr = (t_op'(i_op) == OP_ADD && CW'(r_ptr) < eff_n) ? r_ptr : '0;

    // Following slot, wrapping at the active size.
    assign addr_inc  = CW'(r_addr) + CW'(1);
    assign next_addr = (addr_inc < eff_n) ? AW'(addr_inc) : '0;

    // The read data of this cycle belongs to r_addr.
    assign hit  = (t_op'(r_op) == OP_ADD) ? (i_mem_rdata == '0) : (i_mem_rdata == r_h);
    assign last = (r_iter == eff_n - CW'(1));

    // Memory read address: the first slot on acceptance, then the slot after r_addr.
    assign o_mem_raddr = (r_state == S_IDLE) ? start_addr : next_addr;

    // Memory write: zero fill during the clearing pass, store or clear on a hit.
    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = r_addr;
        o_mem_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_clr;
            end
            S_SCAN: begin
                o_mem_we    = hit;
                o_mem_wdata = (t_op'(r_op) == OP_ADD) ? r_h : '0;
            end
            S_IDLE, S_DONE: begin
                o_mem_we = 1'b0;
            end
            default: begin
                o_mem_we = 1'b0;
            end
        endcase
    end

    // Next-state and data path.
    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        n_ptr   = r_ptr;
        n_count = r_count;
        n_op    = r_op;
        n_h     = r_h;
        n_addr  = r_addr;
        n_iter  = r_iter;
        n_res   = r_res;
        unique case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_op = i_op;
                    n_h  = h_in;
                    if (h_in == '0) begin
                        n_res.status     = ST_ZERO;
                        n_res.slot       = '0;
                        n_res.used_count = COUNT_W'(r_count);
                        n_state          = S_DONE;
                    end else begin
                        n_addr  = start_addr;
                        n_iter  = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (hit) begin
                    if (t_op'(r_op) == OP_ADD) begin
                        if (r_count < CW'(DEPTH)) begin
                            n_count = r_count + CW'(1);
                        end
                        n_ptr = next_addr;
                    end else begin
                        if (r_count != '0) begin
                            n_count = r_count - CW'(1);
                        end
                    end
                    n_res.status     = ST_OK;
                    n_res.slot       = SLOT_W'(r_addr);
                    n_res.used_count = COUNT_W'(n_count);
                    n_state          = S_DONE;
                end else if (last) begin
                    n_res.status     = (t_op'(r_op) == OP_ADD) ? ST_FULL : ST_NOT_FOUND;
                    n_res.slot       = '0;
                    n_res.used_count = COUNT_W'(r_count);
                    n_state          = S_DONE;
                end else begin
                    n_addr = next_addr;
                    n_iter = r_iter + CW'(1);
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Control registers are reset; the scan payload is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_ptr   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ptr   <= n_ptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_h    <= n_h;
        r_addr <= n_addr;
        r_iter <= n_iter;
        r_res  <= n_res;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

>>> rtl/core/nfht_checker.sv
// Port-level checker for the next-fit handle table, bound to the top level.
// Depends on nfht_pkg and the assertion macros header.
`include "next_fit_handle_table_unit_macros.svh"

module nfht_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [nfht_pkg::STATUS_W-1:0] i_out_status,
    input logic [nfht_pkg::SLOT_W-1:0]   i_out_slot,
    input logic [nfht_pkg::COUNT_W-1:0]  i_out_used_count
);
    import nfht_pkg::*;

    // A stalled result holds its payload.
    `NFHT_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_status) && $stable(i_out_slot) && $stable(i_out_used_count)))

    // Any status other than ok reports slot zero.
    `NFHT_ASSERT(a_err_slot_zero, i_clk, i_rst_n, (i_out_valid && i_out_status != ST_OK) |-> (i_out_slot == '0))

    // One transaction at a time: no acceptance in the cycle after one.
    `NFHT_ASSERT(a_one_at_a_time, i_clk, i_rst_n, (i_in_valid && i_in_ready) |=> !i_in_ready)

    // Reset starts the clearing pass, during which nothing is accepted.
    `NFHT_ASSERT_ALWAYS(a_reset_blocks, i_clk, !i_rst_n |=> (!i_in_ready && !i_out_valid))

endmodule

bind next_fit_handle_table_unit nfht_checker u_nfht_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_status     (o_out.status),
    .i_out_slot       (o_out.slot),
    .i_out_used_count (o_out.used_count)
);

>>> tb/sv/next_fit_handle_table_unit_test.sv
// Self-checking testbench for next_fit_handle_table_unit: directed and random add/remove
// traffic, checked against an in-bench model of the next-fit handle table.
// Depends on nfht_pkg and the nfht_req_if / nfht_res_if channel interfaces of the RTL.
module next_fit_handle_table_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import nfht_pkg::*;

    localparam int TABLE_DEPTH   = DEPTH_DEF;
    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 1420;
    localparam int DRAIN_CYCLES  = 80;
    localparam int LONG_HOLD     = 400;
    localparam int RUN_LIMIT_NS  = 20_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [ASIZE_W-1:0] i_cfg_wdata;

    nfht_req_if req_ch ();
    nfht_res_if res_ch ();

    next_fit_handle_table_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (req_ch.sink),
        .o_out       (res_ch.source),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Model of the table: handle slots, next-fit pointer, occupancy and the size register.
    logic [IN_HANDLE_W-1:0] slot_image [TABLE_DEPTH];
    int                     next_fit_ptr;
    int                     occupied;
    logic [ASIZE_W-1:0]     size_reg;

    // Results predicted for accepted transactions, oldest first.
    t_result pending_results [$];

    // Run bookkeeping.
    int fail_count;
    int items_sent;
    int results_seen;
    int size_writes;
    int full_seen;
    int missing_seen;
    int zero_seen;

    // Knobs shared with the idling processes.
    bit src_calm;
    int sink_hold;
    int sink_stall_left;
    int sink_run_left;

    always #HALF_PERIOD i_clk = ~i_clk;

    // Size actually used by the scans: zero counts as one, anything above the depth as the depth.
    function automatic int live_size();
        if (size_reg == '0)
            return 1;
        if (int'(size_reg) > TABLE_DEPTH)
            return TABLE_DEPTH;
        return int'(size_reg);
    endfunction

    // Applies one transaction to the model and returns the result it must produce.
    function automatic t_result apply_to_table(t_op op, logic [IN_HANDLE_W-1:0] handle);
        t_result res;
        int n;
        int idx;
        n = live_size();
        res.slot = '0;
        if (handle == '0) begin
            res.status = ST_ZERO;
        end else if (op == OP_ADD) begin
            res.status = ST_FULL;
            idx = (next_fit_ptr < n) ? next_fit_ptr : 0;
            for (int i = 0; i < n; i++) begin
                if (slot_image[idx] == '0) begin
                    slot_image[idx] = handle;
                    if (occupied < TABLE_DEPTH)
                        occupied++;
                    next_fit_ptr = (idx + 1 < n) ? idx + 1 : 0;
                    res.status = ST_OK;
                    res.slot = SLOT_W'(idx);
                    break;
                end
                idx = (idx + 1 < n) ? idx + 1 : 0;
            end
        end else begin
            res.status = ST_NOT_FOUND;
            for (int i = 0; i < n; i++) begin
                if (slot_image[i] == handle) begin
                    slot_image[i] = '0;
                    if (occupied > 0)
                        occupied--;
                    res.status = ST_OK;
                    res.slot = SLOT_W'(i);
                    break;
                end
            end
        end
        res.used_count = COUNT_W'(occupied);
        return res;
    endfunction

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // A new handle; sometimes from a small pool so that duplicates occur.
    function automatic logic [IN_HANDLE_W-1:0] fresh_handle();
        logic [IN_HANDLE_W-1:0] h;
        if ($urandom_range(0, 5) == 0)
            return IN_HANDLE_W'($urandom_range(1, 8));
        h = $urandom;
        return (h == '0) ? IN_HANDLE_W'(1) : h;
    endfunction

    // A handle currently held in the active part of the table, if there is one.
    function automatic logic [IN_HANDLE_W-1:0] held_handle();
        int n;
        int start;
        n = live_size();
        start = $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++) begin
            if (slot_image[(start + i) % n] != '0)
                return slot_image[(start + i) % n];
        end
        return IN_HANDLE_W'($urandom_range(1, 8));
    endfunction

    // Offers one transaction, waits for the handshake and records the predicted result.
    // Entered and left at a rising edge.
    task automatic send_item(t_op op, logic [IN_HANDLE_W-1:0] handle);
        int gap;
        gap = src_calm ? 0 : pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.op     <= op;
        req_ch.handle <= handle;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_results.push_back(apply_to_table(op, handle));
        items_sent++;
    endtask

    // Lowers valid and waits until every predicted result has been checked.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes the active size register; only called while the block is idle.
    task automatic write_size(logic [ASIZE_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        size_reg = value;
        size_writes++;
    endtask

    // Basic adds and removes at the reset size, with the zero and missing handle cases.
    task automatic test_basic_ops();
        send_item(OP_ADD, 32'hFFFF_FFFF);
        send_item(OP_ADD, 32'h0000_0001);
        send_item(OP_ADD, 32'h8000_0000);
        send_item(OP_REMOVE, 32'h0000_0001);
        send_item(OP_ADD, 32'h0000_0000);
        send_item(OP_REMOVE, 32'h0000_0000);
        send_item(OP_REMOVE, 32'h1234_5678);
        // Next fit goes on after the last fill rather than reusing the freed slot.
        send_item(OP_ADD, 32'hA5A5_A5A5);
    endtask

    // Shrinking the size leaves the pointer outside the active part and the table full.
    task automatic test_wrap_and_full();
        wait_idle();
        write_size(7'd2);
        send_item(OP_ADD, 32'h0000_0002);
        send_item(OP_ADD, 32'h0000_0003);
        // Slot beyond the active part is not searched.
        send_item(OP_REMOVE, 32'h8000_0000);
        send_item(OP_REMOVE, 32'hFFFF_FFFF);
        send_item(OP_ADD, 32'h5A5A_5A5A);
    endtask

    // Size zero behaves as one and sizes above the depth behave as the depth.
    task automatic test_size_clamps();
        wait_idle();
        write_size(7'd0);
        send_item(OP_ADD, 32'h0000_0004);
        send_item(OP_REMOVE, 32'h5A5A_5A5A);
        send_item(OP_ADD, 32'h7FFF_FFFF);
        wait_idle();
        write_size(7'd127);
        send_item(OP_REMOVE, 32'h8000_0000);
        send_item(OP_ADD, 32'h0000_0002);
        send_item(OP_REMOVE, 32'h0000_0002);
    endtask

    // The result side holds off for a long stretch while requests keep coming.
    task automatic test_output_stall();
        wait_idle();
        write_size(7'd64);
        src_calm = 1'b1;
        sink_hold = LONG_HOLD;
        for (int k = 0; k < 24; k++)
            send_item(OP_ADD, fresh_handle());
        src_calm = 1'b0;
    endtask

    // Phases of random traffic, each at a new size written while idle: the first half of a
    // phase mostly fills the table, the second half mostly empties it.
    task automatic test_random_traffic();
        int sent;
        int phase_len;
        int add_bias;
        int r;
        t_op op;
        logic [IN_HANDLE_W-1:0] h;
        logic [ASIZE_W-1:0] size_val;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       size_val = 7'd0;
                1:       size_val = 7'd1;
                2:       size_val = 7'd2;
                3:       size_val = 7'd127;
                4:       size_val = 7'd64;
                5:       size_val = ASIZE_W'($urandom_range(65, 127));
                6, 7:    size_val = ASIZE_W'($urandom_range(3, 12));
                default: size_val = ASIZE_W'($urandom_range(1, 64));
            endcase
            wait_idle();
            write_size(size_val);
            src_calm = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(40, 140);
            for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
                add_bias = (k < phase_len / 2) ? 75 : 35;
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    op = t_op'($urandom_range(0, 1));
                    h = '0;
                end else if (r < 10) begin
                    op = OP_REMOVE;
                    h = $urandom;
                end else if ($urandom_range(0, 99) < add_bias) begin
                    op = OP_ADD;
                    h = fresh_handle();
                end else begin
                    op = OP_REMOVE;
                    h = held_handle();
                end
                send_item(op, h);
                sent++;
            end
        end
        src_calm = 1'b0;
    endtask

    // Result side readiness: random runs and stalls, plus the long hold when asked for.
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold > 0) begin
                sink_stall_left = sink_hold;
                sink_hold = 0;
            end
            if (sink_stall_left > 0) begin
                res_ch.ready <= 1'b0;
                sink_stall_left--;
            end else begin
                res_ch.ready <= 1'b1;
                if (sink_run_left > 0) begin
                    sink_run_left--;
                end else begin
                    sink_run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                                : $urandom_range(1, 20);
                    sink_stall_left = pick_gap();
                end
            end
        end
    end

    // Compares each result transaction with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            results_seen++;
            case (t_status'(res_ch.status))
                ST_FULL:      full_seen++;
                ST_NOT_FOUND: missing_seen++;
                ST_ZERO:      zero_seen++;
                default:      ;
            endcase
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: status %0d slot %0d used_count %0d",
                       res_ch.status, res_ch.slot, res_ch.used_count);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (res_ch.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, res_ch.status);
                    fail_count++;
                end
                if (res_ch.slot !== want.slot) begin
                    $error("slot: expected %0d, actual %0d", want.slot, res_ch.slot);
                    fail_count++;
                end
                if (res_ch.used_count !== want.used_count) begin
                    $error("used_count: expected %0d, actual %0d",
                           want.used_count, res_ch.used_count);
                    fail_count++;
                end
            end
        end
    end

    // Safety net against a hung handshake.
    initial begin
        #(RUN_LIMIT_NS);
        $display("next_fit_handle_table_unit_test: FAIL");
        $finish;
    end

    // Test sequence.
    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        req_ch.valid  <= 1'b0;
        req_ch.op     <= OP_ADD;
        req_ch.handle <= '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            slot_image[i] = '0;
        next_fit_ptr = 0;
        occupied = 0;
        size_reg = ASIZE_RESET;
        src_calm = 1'b0;
        sink_hold = 0;
        sink_stall_left = 0;
        sink_run_left = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_ops();
        test_wrap_and_full();
        test_size_clamps();
        test_output_stall();
        test_random_traffic();

        // Drain, then leave room for any stray result.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end

        $display("Sent %0d requests over %0d size settings; checked %0d results.",
                 items_sent, size_writes, results_seen);
        $display("Results seen: %0d table full, %0d not found, %0d zero handle.",
                 full_seen, missing_seen, zero_seen);
        if (fail_count == 0)
            $display("next_fit_handle_table_unit_test: PASS");
        else
            $display("next_fit_handle_table_unit_test: FAIL");
        $finish;
    end

endmodule
